### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define TCS_ASSERT_NEVER(lbl, cond, msg) \
  `TCS_ASSERT(lbl, !(cond), msg)

`endif

### src/tcs_pkg.sv
// ----------------------------------------------------------------------------
// Turntable capture sequencer package
// Field widths, action and register codes, control structs and decode helpers.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int ACT_W      = 2;
  localparam int FC_W       = 13;
  localparam int DLY_W      = 15;
  localparam int CODE_W     = 5;
  localparam int STEP_OUT_W = 12;
  localparam int PINS_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int OUT_DATA_W = 31;

  // Action codes carried with each input item.
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEP   = 2'd3;

  localparam logic [FC_W-1:0]       FC_RESET     = 13'd1;
  localparam logic [DLY_W-1:0]      SETTLE_RESET = 15'd500;
  localparam logic [DLY_W-1:0]      POST_RESET   = 15'd1500;
  localparam logic [CODE_W-1:0]     CODE_RESET   = 5'd8;
  localparam logic [DLY_W-1:0]      DELAY_LIMIT  = 15'd20000;
  localparam logic [DLY_W-1:0]      ELAPSED_MAX  = 15'h7fff;
  localparam logic [STEP_OUT_W-1:0] STEP_OUT_MAX = 12'hfff;

  // Bit positions of the result fields inside the output data word.
  localparam int OB_SHUTTER = 0;
  localparam int OB_MOVE    = 1;
  localparam int OB_STEPS   = 2;
  localparam int OB_ACTIVE  = 14;
  localparam int OB_FRAMES  = 15;
  localparam int OB_PINS    = 28;

  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
    logic iter;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_busy;
  } status_t;

  // Log2 of the microstep divisor; unsupported codes act as eighth steps.
  function automatic logic [2:0] micro_shift(input logic [CODE_W-1:0] code);
    logic [2:0] sh;
    case (code)
      5'd1:    sh = 3'd0;
      5'd2:    sh = 3'd1;
      5'd4:    sh = 3'd2;
      5'd16:   sh = 3'd4;
      default: sh = 3'd3;
    endcase
    return sh;
  endfunction

  function automatic logic [PINS_W-1:0] micro_pins(input logic [CODE_W-1:0] code);
    logic [PINS_W-1:0] pins;
    case (code)
      5'd1:    pins = 3'd0;
      5'd2:    pins = 3'd1;
      5'd4:    pins = 3'd2;
      5'd16:   pins = 3'd7;
      default: pins = 3'd3;
    endcase
    return pins;
  endfunction

endpackage

### src/tcs_ctrl.sv
// ----------------------------------------------------------------------------
// Turntable capture sequencer controller
// Accepts items, sequences the target divider and commits each result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcs_ctrl #(
  parameter int QUO_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_tvalid_i,
  output logic             in_tready_o,
  input  tcs_pkg::status_t status_i,
  output tcs_pkg::cmd_t    cmd_o
);

  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_tvalid_i;
    cmd_o.mul     = (state_q == ST_EVAL) && status_i.need_div;
    cmd_o.load    = (state_q == ST_LOAD);
    cmd_o.iter    = (state_q == ST_DIV);
    cmd_o.commit  = ((state_q == ST_EVAL && !status_i.need_div) || state_q == ST_DONE)
                    && !status_i.out_busy;
  end

  assign in_tready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_tvalid_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (status_i.need_div) begin
            state_q <= ST_MUL;
          end else if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        ST_MUL: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          cnt_q   <= CNT_W'(QUO_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!status_i.out_busy) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `TCS_ASSERT(a_commit_free, cmd_o.commit |-> !status_i.out_busy, "commit into occupied result register")
  `TCS_ASSERT(a_accept_busy, (in_tvalid_i && in_tready_o) |=> !in_tready_o, "item accepted while busy")

endmodule

### src/tcs_datapath.sv
// ----------------------------------------------------------------------------
// Turntable capture sequencer datapath
// Configuration, sequence state, target divider and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcs_datapath #(
  parameter int HOLD_TICKS         = 60,
  parameter int MIN_MOVE_TICKS     = 20,
  parameter int FULL_STEPS_PER_REV = 200,
  parameter int MAX_FRAMES         = 4096,
  parameter int QUO_W              = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [tcs_pkg::ACT_W-1:0]           item_action_i,
  input  logic                                item_running_i,
  input  logic                                out_tready_i,
  output logic                                out_tvalid_o,
  output logic [tcs_pkg::OUT_DATA_W-1:0]      out_tdata_o,
  output logic                                out_tlast_o,
  input  tcs_pkg::cmd_t                       cmd_i,
  output tcs_pkg::status_t                    status_o
);

  localparam int FULL_W = $clog2(FULL_STEPS_PER_REV + 1);
  localparam int PROD_W = FULL_W + tcs_pkg::FC_W;
  localparam int NUM_W  = PROD_W + 6;
  localparam int DEN_W  = tcs_pkg::FC_W + QUO_W;
  localparam int DIV_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int DIFF_W = (QUO_W > tcs_pkg::STEP_OUT_W) ? QUO_W : tcs_pkg::STEP_OUT_W;

  localparam logic [FULL_W-1:0]             FULL_STEPS = FULL_W'(FULL_STEPS_PER_REV);
  localparam logic [tcs_pkg::DLY_W-1:0]     HOLD_LIM   = tcs_pkg::DLY_W'(HOLD_TICKS);
  localparam logic [tcs_pkg::DLY_W-1:0]     MOVE_LIM   = tcs_pkg::DLY_W'(MIN_MOVE_TICKS);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_HOLD,
    PH_POST,
    PH_MOVE
  } phase_e;

  // Configuration registers.
  logic [tcs_pkg::FC_W-1:0]   fc_q;
  logic [tcs_pkg::DLY_W-1:0]  settle_q;
  logic [tcs_pkg::DLY_W-1:0]  post_q;
  logic [tcs_pkg::CODE_W-1:0] code_q;

  // Sequence state.
  phase_e                     phase_q, phase_d;
  logic [tcs_pkg::DLY_W-1:0]  el_q, el_d, el_inc;
  logic [tcs_pkg::FC_W-1:0]   fi_q, fi_d;
  logic [QUO_W-1:0]           st_q, st_d;
  logic                       sh_q, sh_d;

  // Captured item.
  logic [tcs_pkg::ACT_W-1:0]  act_q;
  logic                       run_q;

  // Divider.
  logic [PROD_W-1:0]          prod_q;
  logic [DIV_W-1:0]           rem_q;
  logic [DIV_W-1:0]           den_q;
  logic [QUO_W-1:0]           quo_q;
  logic [3:0]                 num_shift;
  logic                       rem_ge;

  // Result register.
  logic                       out_valid_q;
  logic [tcs_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                       out_last_q;
  logic                       out_move;
  logic                       out_active;

  logic                             mv_valid, done;
  logic [tcs_pkg::STEP_OUT_W-1:0]   mv_steps;
  logic [DIFF_W-1:0]                diff;
  logic [tcs_pkg::DLY_W-1:0]        cfg_dly;

  assign cfg_dly = (cfg_data_i > tcs_pkg::DELAY_LIMIT) ? tcs_pkg::DELAY_LIMIT : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q     <= tcs_pkg::FC_RESET;
      settle_q <= tcs_pkg::SETTLE_RESET;
      post_q   <= tcs_pkg::POST_RESET;
      code_q   <= tcs_pkg::CODE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tcs_pkg::CFG_FRAME_COUNT: begin
          if (32'(cfg_data_i[tcs_pkg::FC_W-1:0]) > MAX_FRAMES) begin
            fc_q <= tcs_pkg::FC_W'(MAX_FRAMES);
          end else begin
            fc_q <= cfg_data_i[tcs_pkg::FC_W-1:0];
          end
        end
        tcs_pkg::CFG_SETTLE:    settle_q <= cfg_dly;
        tcs_pkg::CFG_POST:      post_q   <= cfg_dly;
        tcs_pkg::CFG_MICROSTEP: code_q   <= cfg_data_i[tcs_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign el_inc = (el_q != tcs_pkg::ELAPSED_MAX) ? el_q + 1'b1 : el_q;

  assign status_o.need_div = (act_q == tcs_pkg::ACT_TICK) && (phase_q == PH_POST) &&
                             (el_inc >= post_q) && (fi_q < fc_q);
  assign status_o.out_busy = out_valid_q && !out_tready_i;

  // The move length comes from the divider quotient, the rounded target.
  assign diff = DIFF_W'(quo_q) - DIFF_W'(st_q);

  always_comb begin
    phase_d  = phase_q;
    el_d     = el_q;
    fi_d     = fi_q;
    st_d     = st_q;
    sh_d     = sh_q;
    mv_valid = 1'b0;
    mv_steps = '0;
    done     = 1'b0;
    case (act_q)
      tcs_pkg::ACT_START: begin
        if (fc_q != '0) begin
          fi_d    = '0;
          st_d    = '0;
          el_d    = '0;
          phase_d = PH_SETTLE;
        end
      end
      tcs_pkg::ACT_STOP: begin
        phase_d = PH_IDLE;
        sh_d    = 1'b0;
      end
      tcs_pkg::ACT_TICK: begin
        if (phase_q != PH_IDLE) begin
          el_d = el_inc;
          case (phase_q)
            PH_SETTLE: begin
              if (el_inc >= settle_q) begin
                sh_d    = 1'b1;
                el_d    = '0;
                phase_d = PH_HOLD;
              end
            end
            PH_HOLD: begin
              if (el_inc >= HOLD_LIM) begin
                sh_d    = 1'b0;
                if (fi_q != '1) fi_d = fi_q + 1'b1;
                el_d    = '0;
                phase_d = PH_POST;
              end
            end
            PH_POST: begin
              if (el_inc >= post_q) begin
                if (fi_q >= fc_q) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  if (quo_q > st_q) begin
                    mv_valid = 1'b1;
                    mv_steps = (diff > DIFF_W'(tcs_pkg::STEP_OUT_MAX)) ?
                               tcs_pkg::STEP_OUT_MAX : diff[tcs_pkg::STEP_OUT_W-1:0];
                  end
                  st_d    = quo_q;
                  el_d    = '0;
                  phase_d = PH_MOVE;
                end
              end
            end
            PH_MOVE: begin
              if (el_inc >= MOVE_LIM && !run_q) begin
                el_d    = '0;
                phase_d = PH_SETTLE;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      el_q    <= '0;
      fi_q    <= '0;
      st_q    <= '0;
      sh_q    <= 1'b0;
    end else if (cmd_i.commit) begin
      phase_q <= phase_d;
      el_q    <= el_d;
      fi_q    <= fi_d;
      st_q    <= st_d;
      sh_q    <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= item_action_i;
      run_q <= item_running_i;
    end
  end

  // Target = floor((2*S*i + N) / (2*N)) with S = FULL_STEPS << shift.
  assign num_shift = {1'b0, tcs_pkg::micro_shift(code_q)} + 4'd1;
  assign rem_ge    = (rem_q >= den_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(FULL_STEPS) * PROD_W'(fi_q);
    end
    if (cmd_i.load) begin
      rem_q <= (DIV_W'(prod_q) << num_shift) + DIV_W'(fc_q);
      den_q <= DIV_W'({fc_q, 1'b0}) << (QUO_W - 1);
      quo_q <= '0;
    end else if (cmd_i.iter) begin
      if (rem_ge) rem_q <= rem_q - den_q;
      den_q <= den_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {tcs_pkg::micro_pins(code_q), fi_d, (phase_d != PH_IDLE),
                     mv_steps, mv_valid, sh_d};
      out_last_q <= done;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;
  assign out_tlast_o  = out_last_q;

  assign out_move   = out_data_q[tcs_pkg::OB_MOVE];
  assign out_active = out_data_q[tcs_pkg::OB_ACTIVE];

  `TCS_ASSERT(a_commit_shows, cmd_i.commit |=> out_tvalid_o, "committed result not presented")
  `TCS_ASSERT_NEVER(a_move_idle, out_tvalid_o && out_move && !out_active, "move outside a run")
  `TCS_ASSERT_NEVER(a_done_active, out_tvalid_o && out_tlast_o && out_active, "run end while active")

endmodule

### src/turntable_capture_sequencer_core.sv
// ----------------------------------------------------------------------------
// Turntable capture sequencer core
// Steps a photo turntable through settle, shutter hold, post wait and move.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  action, motion_running
//  m_axis    out        m_axis_tvalid / m_axis_tready  result fields, run_done
//  cfg       in         cfg_valid_i / cfg_ready_o      register index and data
//
// An item that issues no move passes from transfer through the evaluate state
// back to idle before the next possible transfer; one that ends a post wait with a
// move runs the shift-subtract target divider, one quotient bit a cycle.
// The result register lets a new item transfer while a result waits; a
// commit waits only while that register is still full and m_axis_tready is low.
// Reset is asynchronous and active low; configuration writes are always taken.
// ----------------------------------------------------------------------------
module turntable_capture_sequencer_core #(
  parameter int HOLD_TICKS         = 60,
  parameter int MIN_MOVE_TICKS     = 20,
  parameter int FULL_STEPS_PER_REV = 200,
  parameter int MAX_FRAMES         = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] motion_running
  input  logic [tcs_pkg::ACT_W-1:0]       s_axis_tuser,  // [1:0] action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] shutter_pressed, [1] move_valid, [13:2] move_steps, [14] run_active,
  // [27:15] frames_taken, [30:28] microstep_pins, [31] zero
  output logic [31:0]                     m_axis_tdata,
  output logic                            m_axis_tlast,  // run_done
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int QUO_W = $clog2(FULL_STEPS_PER_REV * 16 + 1);

  tcs_pkg::cmd_t                  cmd;
  tcs_pkg::status_t               status;
  logic [tcs_pkg::OUT_DATA_W-1:0] out_data;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {1'b0, out_data};

  tcs_ctrl #(
    .QUO_W (QUO_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcs_datapath #(
    .HOLD_TICKS         (HOLD_TICKS),
    .MIN_MOVE_TICKS     (MIN_MOVE_TICKS),
    .FULL_STEPS_PER_REV (FULL_STEPS_PER_REV),
    .MAX_FRAMES         (MAX_FRAMES),
    .QUO_W              (QUO_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_action_i  (s_axis_tuser),
    .item_running_i (s_axis_tdata[0]),
    .out_tready_i   (m_axis_tready),
    .out_tvalid_o   (m_axis_tvalid),
    .out_tdata_o    (out_data),
    .out_tlast_o    (m_axis_tlast),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule
